>>> rtl/mht_pkg.sv
// ----------------------------------------------------------------------------
// mht_pkg: shared types and constants of the move history / killer tables
// Field widths, operation codes, sequencer states and the halving helper.
// ----------------------------------------------------------------------------
package mht_pkg;

  localparam int unsigned HIST_W      = 20;  // signed history score
  localparam int unsigned HIST_LIM_W  = 18;  // history limit register
  localparam int unsigned IO_MOVE_W   = 16;  // move words on the ports
  localparam int unsigned SQ_IDX_W    = 6;   // square fields
  localparam int unsigned PIECE_W     = 4;   // piece kind field
  localparam int unsigned DEPTH_W     = 6;   // depth field
  localparam int unsigned PLY_W       = 6;   // ply field
  localparam int unsigned DSQ_W       = 2 * DEPTH_W;  // depth squared

  localparam logic [HIST_LIM_W-1:0] HIST_LIM_RST = HIST_LIM_W'(65536);

  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_REWARD  = 2'd0,
    KIND_PENALTY = 2'd1,
    KIND_LOOKUP  = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_HALVE,
    ST_CLEAR,
    ST_DONE
  } state_e;

  // divide by two, truncating toward zero
  function automatic logic signed [HIST_W-1:0] hist_half(input logic signed [HIST_W-1:0] v);
    logic signed [HIST_W-1:0] adj;
    adj = v + $signed({{(HIST_W-1){1'b0}}, v[HIST_W-1]});
    return adj >>> 1;
  endfunction

endpackage

>>> rtl/move_history_killer_tables_unit.sv
// ----------------------------------------------------------------------------
// move_history_killer_tables_unit: move-ordering tables of a tree search
// History scores, refutation moves and killer pairs, updated by a sequencer.
// ----------------------------------------------------------------------------
// One input transaction runs reward, penalty, lookup or clear and returns
// exactly one result transaction. Lookup, reward and penalty pass through
// accept, table read, compute and write back, and result load; the tables sit
// in registered-read RAMs, so every reward or penalty is a read-modify-write
// through the one update datapath. When a reward or penalty pushes its
// history entry past +/- the history limit, a halving sweep walks the whole
// history RAM, one entry per cycle through the halver. A clear walks all
// RAMs, writing zeros. The same clearing pass runs once after reset, during
// which in_stall_o is high; history limit writes are taken at any time. The
// input side stalls while an item is in flight; the result sits in an output
// register, so a new item may be accepted while the previous result is still
// stalled.
// ----------------------------------------------------------------------------
module move_history_killer_tables_unit
  import mht_pkg::*;
#(
  parameter int unsigned PLY_COUNT    = 64,
  parameter int unsigned PIECE_KINDS  = 12,
  parameter int unsigned SQUARE_COUNT = 64,
  parameter int unsigned MOVE_WIDTH   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write channel (history limit)
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [HIST_LIM_W-1:0]      cfg_data_i,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 kind_i,
  input  logic [IO_MOVE_W-1:0]       move_i,
  input  logic [SQ_IDX_W-1:0]        from_sq_i,
  input  logic [SQ_IDX_W-1:0]        to_sq_i,
  input  logic [PIECE_W-1:0]         moving_piece_i,
  input  logic                       material_change_i,
  input  logic [DEPTH_W-1:0]         depth_i,
  input  logic [PLY_W-1:0]           ply_i,
  input  logic [SQ_IDX_W-1:0]        last_from_sq_i,
  input  logic [SQ_IDX_W-1:0]        last_to_sq_i,
  input  logic                       last_valid_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [HIST_W-1:0]   history_score_o,
  output logic [IO_MOVE_W-1:0]       refutation_move_o,
  output logic [IO_MOVE_W-1:0]       killer_first_o,
  output logic [IO_MOVE_W-1:0]       killer_second_o,
  output logic                       halved_o
);

  // --------------------------------------------------------------------------
  // Sizes
  // --------------------------------------------------------------------------
  localparam int unsigned HIST_DEPTH  = PIECE_KINDS * SQUARE_COUNT;
  localparam int unsigned REF_DEPTH   = SQUARE_COUNT * SQUARE_COUNT;
  localparam int unsigned SWEEP_A     = (HIST_DEPTH > REF_DEPTH) ? HIST_DEPTH : REF_DEPTH;
  localparam int unsigned SWEEP_DEPTH = (SWEEP_A > PLY_COUNT) ? SWEEP_A : PLY_COUNT;
  localparam int unsigned HIST_AW     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned REF_AW      = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned KIL_AW      = (PLY_COUNT > 1) ? $clog2(PLY_COUNT) : 1;
  localparam int unsigned CNT_W       = $clog2(SWEEP_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     emit_q, emit_d;      // clear sweep ends in a result
  logic                     out_valid_q, out_valid_d;
  logic [HIST_LIM_W-1:0]    hist_limit_q;

  // latched item
  logic                     ld_in;
  kind_e                    kind_q;
  logic [MOVE_WIDTH-1:0]    move_q;
  logic [SQ_IDX_W-1:0]      fsq_q, tsq_q, lfsq_q, ltsq_q;
  logic [PIECE_W-1:0]       pc_q;
  logic                     mat_q, lvalid_q;
  logic [DEPTH_W-1:0]       depth_q;
  logic [PLY_W-1:0]         ply_q;
  logic [DSQ_W-1:0]         dsq_q, dsq_d;

  // pending result
  logic signed [HIST_W-1:0] res_hist_q, res_hist_d;
  logic [IO_MOVE_W-1:0]     res_ref_q, res_ref_d;
  logic [IO_MOVE_W-1:0]     res_kf_q, res_kf_d;
  logic [IO_MOVE_W-1:0]     res_ks_q, res_ks_d;
  logic                     res_halved_q, res_halved_d;
  logic                     ld_out;

  // output register
  logic signed [HIST_W-1:0] out_hist_q;
  logic [IO_MOVE_W-1:0]     out_ref_q, out_kf_q, out_ks_q;
  logic                     out_halved_q;

  // --------------------------------------------------------------------------
  // RAM ports
  // --------------------------------------------------------------------------
  logic                     hist_we;
  logic [HIST_AW-1:0]       hist_waddr, hist_raddr;
  logic signed [HIST_W-1:0] hist_wdata, hist_rdata;

  logic                     ref_we;
  logic [REF_AW-1:0]        ref_waddr, ref_raddr;
  logic [MOVE_WIDTH-1:0]    ref_wdata, ref_rdata;

  logic                     kil_we;
  logic [KIL_AW-1:0]        kil_addr;
  logic [MOVE_WIDTH-1:0]    kf_wdata, kf_rdata, ks_wdata, ks_rdata;

  mht_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  mht_ram #(.WIDTH(MOVE_WIDTH), .DEPTH(REF_DEPTH)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

  mht_ram #(.WIDTH(MOVE_WIDTH), .DEPTH(PLY_COUNT)) u_kf_ram (
    .clk_i   (clk_i),
    .we_i    (kil_we),
    .waddr_i (kil_addr),
    .wdata_i (kf_wdata),
    .raddr_i (kil_addr),
    .rdata_o (kf_rdata)
  );

  mht_ram #(.WIDTH(MOVE_WIDTH), .DEPTH(PLY_COUNT)) u_ks_ram (
    .clk_i   (clk_i),
    .we_i    (kil_we),
    .waddr_i (kil_addr),
    .wdata_i (ks_wdata),
    .raddr_i (kil_addr),
    .rdata_o (ks_rdata)
  );

  // --------------------------------------------------------------------------
  // Address decode and range checks of the latched item
  // --------------------------------------------------------------------------
  logic               hist_ok, ref_ok, lref_ok, ply_ok;
  logic [HIST_AW-1:0] hidx;
  logic [REF_AW-1:0]  ridx, lridx;
  logic [CNT_W-1:0]   cnt_m1;

  assign hist_ok = (32'(pc_q) < PIECE_KINDS) && (32'(tsq_q) < SQUARE_COUNT);
  assign ref_ok  = (32'(fsq_q) < SQUARE_COUNT) && (32'(tsq_q) < SQUARE_COUNT);
  assign lref_ok = (32'(lfsq_q) < SQUARE_COUNT) && (32'(ltsq_q) < SQUARE_COUNT);
  assign ply_ok  = 32'(ply_q) < PLY_COUNT;
  assign hidx    = HIST_AW'(32'(pc_q) * SQUARE_COUNT + 32'(tsq_q));
  assign ridx    = REF_AW'(32'(fsq_q) * SQUARE_COUNT + 32'(tsq_q));
  assign lridx   = REF_AW'(32'(lfsq_q) * SQUARE_COUNT + 32'(ltsq_q));
  assign cnt_m1  = cnt_q - CNT_W'(1);

  // --------------------------------------------------------------------------
  // Update datapath: one saturating add and a limit compare
  // --------------------------------------------------------------------------
  localparam int unsigned LIM_PAD = HIST_W + 1 - HIST_LIM_W;
  localparam int unsigned RWD_PAD = HIST_W - DSQ_W;      // 2*d^2 = dsq << 1
  localparam int unsigned PEN_PAD = HIST_W + 1 - DSQ_W;

  logic                     is_reward, is_penalty, upd;
  logic signed [HIST_W:0]   delta_w, sum_w, lim_w, new_ext;
  logic signed [HIST_W-1:0] new_hist;
  logic                     over_lim, do_halve, upd_ref, upd_kil;

  always_comb begin
    is_reward  = (kind_q == KIND_REWARD);
    is_penalty = (kind_q == KIND_PENALTY);
    upd        = (is_reward || is_penalty) && !mat_q;
    delta_w    = is_reward ? $signed({{RWD_PAD{1'b0}}, dsq_q, 1'b0})
                           : -$signed({{PEN_PAD{1'b0}}, dsq_q});
    sum_w      = $signed({hist_rdata[HIST_W-1], hist_rdata}) + delta_w;
    if (sum_w[HIST_W] != sum_w[HIST_W-1]) begin
      new_hist = sum_w[HIST_W] ? HIST_MIN : HIST_MAX;
    end else begin
      new_hist = sum_w[HIST_W-1:0];
    end
    new_ext  = {new_hist[HIST_W-1], new_hist};
    lim_w    = $signed({{LIM_PAD{1'b0}}, hist_limit_q});
    over_lim = is_reward ? (new_ext > lim_w) : (new_ext < -lim_w);
    do_halve = upd && hist_ok && over_lim;
    upd_ref  = is_reward && !mat_q && lvalid_q && lref_ok;
    // the killer pair shifts only when the move is not already first
    upd_kil  = is_reward && !mat_q && ply_ok && (move_q != kf_rdata);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    emit_d       = emit_q;
    ld_in        = 1'b0;
    ld_out       = 1'b0;
    dsq_d        = dsq_q;
    res_hist_d   = res_hist_q;
    res_ref_d    = res_ref_q;
    res_kf_d     = res_kf_q;
    res_ks_d     = res_ks_q;
    res_halved_d = res_halved_q;

    hist_we    = 1'b0;
    hist_waddr = hidx;
    hist_wdata = new_hist;
    hist_raddr = hidx;
    ref_we     = 1'b0;
    ref_waddr  = lridx;
    ref_wdata  = move_q;
    ref_raddr  = ridx;
    kil_we     = 1'b0;
    kil_addr   = KIL_AW'(ply_q);
    kf_wdata   = move_q;
    ks_wdata   = kf_rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ld_in = 1'b1;
          if (kind_e'(kind_i) == KIND_CLEAR) begin
            emit_d  = 1'b1;
            cnt_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_READ;
          end
        end
      end

      ST_READ: begin
        // RAM reads issue on the default addresses
        dsq_d   = DSQ_W'(depth_q * depth_q);
        state_d = ST_CALC;
      end

      ST_CALC: begin
        hist_we = upd && hist_ok;
        ref_we  = upd_ref;
        kil_we  = upd_kil;

        if (!hist_ok) begin
          res_hist_d = '0;
        end else if (upd) begin
          res_hist_d = new_hist;
        end else begin
          res_hist_d = hist_rdata;
        end

        if (!ref_ok) begin
          res_ref_d = '0;
        end else if (upd_ref && (lridx == ridx)) begin
          res_ref_d = IO_MOVE_W'(move_q);
        end else begin
          res_ref_d = IO_MOVE_W'(ref_rdata);
        end

        if (!ply_ok) begin
          res_kf_d = '0;
          res_ks_d = '0;
        end else if (upd_kil) begin
          res_kf_d = IO_MOVE_W'(move_q);
          res_ks_d = IO_MOVE_W'(kf_rdata);
        end else begin
          res_kf_d = IO_MOVE_W'(kf_rdata);
          res_ks_d = IO_MOVE_W'(ks_rdata);
        end

        res_halved_d = do_halve;
        if (do_halve) begin
          cnt_d   = '0;
          state_d = ST_HALVE;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_HALVE: begin
        // read entry cnt, write back entry cnt-1 halved
        hist_raddr = cnt_q[HIST_AW-1:0];
        hist_waddr = cnt_m1[HIST_AW-1:0];
        hist_wdata = hist_half(hist_rdata);
        hist_we    = (cnt_q != '0);
        if (cnt_q == CNT_W'(HIST_DEPTH)) begin
          res_hist_d = hist_half(res_hist_q);
          cnt_d      = '0;
          state_d    = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      ST_CLEAR: begin
        hist_waddr = cnt_q[HIST_AW-1:0];
        hist_wdata = '0;
        hist_we    = 32'(cnt_q) < HIST_DEPTH;
        ref_waddr  = cnt_q[REF_AW-1:0];
        ref_wdata  = '0;
        ref_we     = 32'(cnt_q) < REF_DEPTH;
        kil_addr   = cnt_q[KIL_AW-1:0];
        kf_wdata   = '0;
        ks_wdata   = '0;
        kil_we     = 32'(cnt_q) < PLY_COUNT;
        if (cnt_q == CNT_W'(SWEEP_DEPTH - 1)) begin
          res_hist_d   = '0;
          res_ref_d    = '0;
          res_kf_d     = '0;
          res_ks_d     = '0;
          res_halved_d = 1'b0;
          cnt_d        = '0;
          emit_d       = 1'b0;
          state_d      = emit_q ? ST_DONE : ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ld_out  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ld_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers: reset starts the clearing pass with no result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      emit_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      hist_limit_q <= HIST_LIM_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        hist_limit_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      kind_q   <= kind_e'(kind_i);
      move_q   <= MOVE_WIDTH'(move_i);
      fsq_q    <= from_sq_i;
      tsq_q    <= to_sq_i;
      pc_q     <= moving_piece_i;
      mat_q    <= material_change_i;
      depth_q  <= depth_i;
      ply_q    <= ply_i;
      lfsq_q   <= last_from_sq_i;
      ltsq_q   <= last_to_sq_i;
      lvalid_q <= last_valid_i;
    end
    dsq_q        <= dsq_d;
    res_hist_q   <= res_hist_d;
    res_ref_q    <= res_ref_d;
    res_kf_q     <= res_kf_d;
    res_ks_q     <= res_ks_d;
    res_halved_q <= res_halved_d;
    if (ld_out) begin
      out_hist_q   <= res_hist_q;
      out_ref_q    <= res_ref_q;
      out_kf_q     <= res_kf_q;
      out_ks_q     <= res_ks_q;
      out_halved_q <= res_halved_q;
    end
  end

  // --------------------------------------------------------------------------
  // Ports
  // --------------------------------------------------------------------------
  assign cfg_ready_o       = 1'b1;
  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign history_score_o   = out_hist_q;
  assign refutation_move_o = out_ref_q;
  assign killer_first_o    = out_kf_q;
  assign killer_second_o   = out_ks_q;
  assign halved_o          = out_halved_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start the sequencer");

  a_done_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && !(out_valid_q && out_stall_i) |=> out_valid_o)
    else $error("finished item did not reach the output register");

  a_hist_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |-> 32'(hist_waddr) < HIST_DEPTH)
    else $error("history write beyond table depth");

  a_halved_magnitude: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halved_o |->
      (history_score_o <= $signed(20'sd262144)) && (history_score_o >= -$signed(20'sd262144)))
    else $error("halved result out of half range");

endmodule

>>> rtl/mht_ram.sv
// ----------------------------------------------------------------------------
// mht_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module mht_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: move history / killer tables unit
// Drives reward, penalty, lookup and clear transactions through the block,
// keeps its own copy of the history, refutation and killer tables, and checks
// every result transaction field by field against that copy. Runs directed
// passes, then random phases under several history limit settings.
// ----------------------------------------------------------------------------
module testbench
  import mht_pkg::*;
();

  localparam int NUM_PLIES   = 64;
  localparam int NUM_PIECES  = 12;
  localparam int NUM_SQUARES = 64;
  // Longest legal quiet spell is a clear sweep or the clearing pass after
  // reset, plus output stalls.
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    kind_e                 kind;
    logic [IO_MOVE_W-1:0]  move;
    logic [SQ_IDX_W-1:0]   from_sq;
    logic [SQ_IDX_W-1:0]   to_sq;
    logic [PIECE_W-1:0]    piece;
    logic                  material;
    logic [DEPTH_W-1:0]    depth;
    logic [PLY_W-1:0]      ply;
    logic [SQ_IDX_W-1:0]   last_from;
    logic [SQ_IDX_W-1:0]   last_to;
    logic                  last_valid;
  } move_item_t;

  typedef struct packed {
    logic [HIST_W-1:0]     history;
    logic [IO_MOVE_W-1:0]  refutation;
    logic [IO_MOVE_W-1:0]  killer_a;
    logic [IO_MOVE_W-1:0]  killer_b;
    logic                  halved;
  } table_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [HIST_LIM_W-1:0]  cfg_data = '0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  move_item_t             cur_move = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [HIST_W-1:0] history_score;
  logic [IO_MOVE_W-1:0]   refutation_move;
  logic [IO_MOVE_W-1:0]   killer_first;
  logic [IO_MOVE_W-1:0]   killer_second;
  logic                   halved;

  // shadow copy of the block's tables and register
  int                     hist_tbl   [NUM_PIECES*NUM_SQUARES];
  logic [IO_MOVE_W-1:0]   refut_tbl  [NUM_SQUARES*NUM_SQUARES];
  logic [IO_MOVE_W-1:0]   killer1_tbl[NUM_PLIES];
  logic [IO_MOVE_W-1:0]   killer2_tbl[NUM_PLIES];
  logic [HIST_LIM_W-1:0]  hist_limit_cfg = HIST_LIM_RST;

  move_item_t             pending_moves[$];
  table_view_t            expected_views[$];
  logic                   calm = 1'b0;     // no idling on either side
  logic [IO_MOVE_W-1:0]   recent_move = '0;
  int                     mismatches = 0;
  int                     quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  move_history_killer_tables_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .kind_i            (cur_move.kind),
    .move_i            (cur_move.move),
    .from_sq_i         (cur_move.from_sq),
    .to_sq_i           (cur_move.to_sq),
    .moving_piece_i    (cur_move.piece),
    .material_change_i (cur_move.material),
    .depth_i           (cur_move.depth),
    .ply_i             (cur_move.ply),
    .last_from_sq_i    (cur_move.last_from),
    .last_to_sq_i      (cur_move.last_to),
    .last_valid_i      (cur_move.last_valid),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .history_score_o   (history_score),
    .refutation_move_o (refutation_move),
    .killer_first_o    (killer_first),
    .killer_second_o   (killer_second),
    .halved_o          (halved)
  );

  // History sums clamp to the 20-bit signed range before the limit compare.
  function automatic int clamp_hist(input int s);
    if (s > int'(HIST_MAX)) return int'(HIST_MAX);
    if (s < int'(HIST_MIN)) return int'(HIST_MIN);
    return s;
  endfunction

  // Applies one transaction to the shadow tables and returns what the block
  // should report afterwards.
  task automatic update_tables(input move_item_t m, output table_view_t v);
    int  hidx;
    int  sqd;
    int  lim;
    logic hist_ok;
    logic ref_ok;
    logic ply_ok;
    logic sweep;
    hist_ok = int'(m.piece) < NUM_PIECES && int'(m.to_sq) < NUM_SQUARES;
    ref_ok  = int'(m.from_sq) < NUM_SQUARES && int'(m.to_sq) < NUM_SQUARES;
    ply_ok  = int'(m.ply) < NUM_PLIES;
    hidx    = hist_ok ? int'(m.piece) * NUM_SQUARES + int'(m.to_sq) : 0;
    sqd     = int'(m.depth) * int'(m.depth);
    lim     = int'(hist_limit_cfg);
    sweep   = 1'b0;
    case (m.kind)
      KIND_CLEAR: begin
        foreach (hist_tbl[i]) hist_tbl[i] = 0;
        foreach (refut_tbl[i]) refut_tbl[i] = '0;
        foreach (killer1_tbl[i]) begin
          killer1_tbl[i] = '0;
          killer2_tbl[i] = '0;
        end
      end
      KIND_REWARD: if (!m.material) begin
        if (hist_ok) begin
          hist_tbl[hidx] = clamp_hist(hist_tbl[hidx] + 2 * sqd);
          sweep = hist_tbl[hidx] > lim;
        end
        if (m.last_valid && int'(m.last_from) < NUM_SQUARES && int'(m.last_to) < NUM_SQUARES)
          refut_tbl[int'(m.last_from) * NUM_SQUARES + int'(m.last_to)] = m.move;
        // a move that already leads the pair does not push the second out
        if (ply_ok && m.move != killer1_tbl[m.ply]) begin
          killer2_tbl[m.ply] = killer1_tbl[m.ply];
          killer1_tbl[m.ply] = m.move;
        end
      end
      KIND_PENALTY: if (!m.material && hist_ok) begin
        hist_tbl[hidx] = clamp_hist(hist_tbl[hidx] - sqd);
        sweep = hist_tbl[hidx] < -lim;
      end
      default: ;
    endcase
    // SV integer division truncates toward zero, same as the halver
    if (sweep) foreach (hist_tbl[i]) hist_tbl[i] = hist_tbl[i] / 2;
    v.history    = hist_ok ? HIST_W'(hist_tbl[hidx]) : '0;
    v.refutation = ref_ok ? refut_tbl[int'(m.from_sq) * NUM_SQUARES + int'(m.to_sq)] : '0;
    v.killer_a   = ply_ok ? killer1_tbl[m.ply] : '0;
    v.killer_b   = ply_ok ? killer2_tbl[m.ply] : '0;
    v.halved     = sweep;
  endtask

  function automatic move_item_t mk_move(input kind_e k, input logic [15:0] mv,
                                         input int fsq, input int tsq, input int pc,
                                         input int mat, input int dep, input int ply,
                                         input int lf, input int lt, input int lv);
    move_item_t m;
    m.kind       = k;
    m.move       = mv;
    m.from_sq    = SQ_IDX_W'(fsq);
    m.to_sq      = SQ_IDX_W'(tsq);
    m.piece      = PIECE_W'(pc);
    m.material   = (mat != 0);
    m.depth      = DEPTH_W'(dep);
    m.ply        = PLY_W'(ply);
    m.last_from  = SQ_IDX_W'(lf);
    m.last_to    = SQ_IDX_W'(lt);
    m.last_valid = (lv != 0);
    return m;
  endfunction

  // Mostly a few hot squares and plies, so entries build up, halve, and
  // lookups land on stored refutations and killers.
  function automatic logic [5:0] hot_index();
    return ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 3)) : 6'($urandom);
  endfunction

  function automatic move_item_t random_move();
    move_item_t m;
    int pick;
    pick = $urandom_range(0, 199);
    if (pick == 0)        m.kind = KIND_CLEAR;
    else if (pick < 90)   m.kind = KIND_REWARD;
    else if (pick < 150)  m.kind = KIND_PENALTY;
    else                  m.kind = KIND_LOOKUP;
    m.move      = ($urandom_range(0, 3) == 0) ? recent_move : IO_MOVE_W'($urandom);
    m.from_sq   = hot_index();
    m.to_sq     = hot_index();
    pick = $urandom_range(0, 99);
    if (pick < 15)        m.piece = PIECE_W'($urandom_range(12, 15));  // no such piece
    else if (pick < 70)   m.piece = PIECE_W'($urandom_range(0, 2));
    else                  m.piece = PIECE_W'($urandom_range(0, 11));
    m.material  = $urandom_range(0, 99) < 15;
    pick = $urandom_range(0, 9);
    m.depth     = (pick == 0) ? '0 : (pick == 1) ? '1 : DEPTH_W'($urandom);
    m.ply       = hot_index();
    m.last_from = hot_index();
    m.last_to   = hot_index();
    m.last_valid = $urandom_range(0, 9) < 7;
    if (m.kind == KIND_REWARD) recent_move = m.move;
    return m;
  endfunction

  function automatic void check_field(input string what, input logic [19:0] want,
                                      input logic [19:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Waits until every queued transaction has gone in and its result came back.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_moves.size() != 0 || in_valid || expected_views.size() != 0);
  endtask

  task automatic write_hist_limit(input logic [HIST_LIM_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid      <= 1'b0;
    hist_limit_cfg = value;
  endtask

  // Driver: holds the payload while stalled, may idle between transactions.
  always @(posedge clk_i) begin : drive_moves
    table_view_t view;
    logic        load;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      load = !in_valid;
      if (in_valid && !in_stall) begin
        update_tables(cur_move, view);
        expected_views.push_back(view);
        load = 1'b1;
      end
      if (load) begin
        if (pending_moves.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
          cur_move <= pending_moves.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest expected view.
  always @(posedge clk_i) begin : check_views
    table_view_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result transaction with nothing expected", $time);
          mismatches++;
        end else begin
          want = expected_views.pop_front();
          check_field("history_score", want.history, history_score);
          check_field("refutation_move", 20'(want.refutation), 20'(refutation_move));
          check_field("killer_first", 20'(want.killer_a), 20'(killer_first));
          check_field("killer_second", 20'(want.killer_b), 20'(killer_second));
          check_field("halved", 20'(want.halved), 20'(halved));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 36);
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_phases
    logic [HIST_LIM_W-1:0] limits[5];
    int                    counts[5];
    foreach (hist_tbl[i]) hist_tbl[i] = 0;
    foreach (refut_tbl[i]) refut_tbl[i] = '0;
    foreach (killer1_tbl[i]) begin
      killer1_tbl[i] = '0;
      killer2_tbl[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, at the reset value of the history limit.
    pending_moves.push_back(mk_move(KIND_LOOKUP, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_moves.push_back(mk_move(KIND_REWARD, 16'hffff, 0, 0, 0, 0, 63, 0, 0, 0, 1));
    // same move again: already first killer, pair stays
    pending_moves.push_back(mk_move(KIND_REWARD, 16'hffff, 0, 0, 0, 0, 63, 0, 0, 0, 1));
    pending_moves.push_back(mk_move(KIND_REWARD, 16'h0000, 63, 63, 11, 0, 0, 63, 63, 63, 1));
    pending_moves.push_back(mk_move(KIND_REWARD, 16'h1234, 63, 63, 11, 0, 1, 63, 63, 63, 0));
    pending_moves.push_back(mk_move(KIND_PENALTY, 16'h5555, 63, 63, 11, 0, 63, 63, 0, 0, 1));
    // piece kinds past the table
    pending_moves.push_back(mk_move(KIND_REWARD, 16'haaaa, 5, 9, 12, 0, 63, 7, 5, 9, 1));
    pending_moves.push_back(mk_move(KIND_PENALTY, 16'h00ff, 5, 9, 15, 0, 63, 7, 5, 9, 1));
    // material change blocks both updates
    pending_moves.push_back(mk_move(KIND_REWARD, 16'h7777, 0, 0, 0, 1, 63, 0, 0, 0, 1));
    pending_moves.push_back(mk_move(KIND_PENALTY, 16'h7777, 0, 0, 0, 1, 63, 0, 0, 0, 1));
    pending_moves.push_back(mk_move(KIND_REWARD, 16'habcd, 1, 2, 4, 0, 31, 5, 1, 2, 0));
    pending_moves.push_back(mk_move(KIND_LOOKUP, 16'hffff, 63, 63, 11, 1, 63, 63, 63, 63, 1));
    pending_moves.push_back(mk_move(KIND_CLEAR, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_moves.push_back(mk_move(KIND_LOOKUP, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Smallest limit: halving on both signs, truncation of odd negatives.
    write_hist_limit(HIST_LIM_W'(1));
    pending_moves.push_back(mk_move(KIND_REWARD, 16'h0101, 3, 9, 3, 0, 1, 2, 3, 9, 1));
    pending_moves.push_back(mk_move(KIND_PENALTY, 16'h0101, 3, 9, 3, 0, 2, 2, 3, 9, 1));
    pending_moves.push_back(mk_move(KIND_PENALTY, 16'h0101, 3, 9, 3, 0, 1, 2, 3, 9, 1));
    pending_moves.push_back(mk_move(KIND_REWARD, 16'h0202, 3, 9, 3, 0, 0, 2, 3, 9, 1));
    pending_moves.push_back(mk_move(KIND_PENALTY, 16'h0202, 3, 9, 3, 0, 0, 2, 3, 9, 1));
    pending_moves.push_back(mk_move(KIND_LOOKUP, 16'h0000, 3, 9, 3, 0, 0, 2, 0, 0, 0));
    drain();

    // Random phases; the third runs with no idling on either side.
    limits = '{HIST_LIM_W'(262143), HIST_LIM_W'(1), HIST_LIM_W'($urandom_range(100, 5000)),
               HIST_LIM_RST, HIST_LIM_W'($urandom_range(1, 262143))};
    counts = '{400, 60, 400, 400, 340};
    for (int p = 0; p < 5; p++) begin
      write_hist_limit(limits[p]);
      calm = (p == 2);
      repeat (counts[p]) pending_moves.push_back(random_move());
      drain();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mht_pkg.sv
rtl/mht_ram.sv
rtl/move_history_killer_tables_unit.sv
sim/testbench.sv
